// ===== design/fifo_evicting_key_value_table_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the key/value table
// Shared forms for same-cycle and next-cycle implications on clk and rst.
// ----------------------------------------------------------------------------
`ifndef FIFO_EVICTING_KEY_VALUE_TABLE_ASSERT_SVH
`define FIFO_EVICTING_KEY_VALUE_TABLE_ASSERT_SVH

// The consequent must hold in the same cycle as the trigger.
`define KVT_ASSERT_SAME(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the trigger.
`define KVT_ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/kvt_pkg.sv =====
// ----------------------------------------------------------------------------
// kvt_pkg
// Types, constants and helpers for the FIFO-replacement key/value table.
// ----------------------------------------------------------------------------
package kvt_pkg;

  localparam int ENTRIES = 8;
  localparam int KEY_W   = 32;
  localparam int VAL_W   = 32;
  localparam int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int SUM_W   = CNT_W + 1;

  typedef logic [KEY_W-1:0]        key_t;
  typedef logic signed [VAL_W-1:0] value_t;
  typedef logic [ADDR_W-1:0]       addr_t;
  typedef logic [CNT_W-1:0]        cnt_t;

  typedef enum logic {
    OP_ADD    = 1'b0,
    OP_ACCESS = 1'b1
  } kvt_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_DONE
  } kvt_state_t;

  // Physical slot of the entry that lies off places after the oldest one.
  function automatic addr_t wrap_addr(addr_t head, cnt_t off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(head) + SUM_W'(off);
    if (sum >= SUM_W'(ENTRIES)) begin
      sum = sum - SUM_W'(ENTRIES);
    end
    return sum[ADDR_W-1:0];
  endfunction

endpackage

// ===== design/kvt_req_if.sv =====
// ----------------------------------------------------------------------------
// kvt_req_if
// Request channel: one add or access word with valid/ready handshake.
// ----------------------------------------------------------------------------
interface kvt_req_if;
  import kvt_pkg::*;

  logic    valid;
  logic    ready;
  kvt_op_t op;
  key_t    key;
  value_t  entry_value;

  modport source (output valid, output op, output key, output entry_value, input ready);
  modport sink   (input valid, input op, input key, input entry_value, output ready);
endinterface

// ===== design/kvt_rsp_if.sv =====
// ----------------------------------------------------------------------------
// kvt_rsp_if
// Response channel: hit flag, read value and eviction flag per request.
// ----------------------------------------------------------------------------
interface kvt_rsp_if;
  import kvt_pkg::*;

  logic   valid;
  logic   ready;
  logic   hit;
  value_t read_value;
  logic   evicted;

  modport source (output valid, output hit, output read_value, output evicted, input ready);
  modport sink   (input valid, input hit, input read_value, input evicted, output ready);
endinterface

// ===== design/kvt_ram.sv =====
// ----------------------------------------------------------------------------
// kvt_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module kvt_ram #(
  parameter  int WIDTH = 32,
  parameter  int DEPTH = 8,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/fifo_evicting_key_value_table.sv =====
// ----------------------------------------------------------------------------
// fifo_evicting_key_value_table
// Fully associative key/value table with first-in-first-out replacement.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one word per request: op (add or access), key, entry_value.
//   rsp returns one word per request: hit, read_value, evicted.
//   Keys and values sit in two RAMs arranged as a ring; head marks the
//   oldest slot, so eviction overwrites the head slot and advances it
//   instead of shifting every entry.
//   A request scans the valid entries oldest first, one RAM read and one
//   compare per entry, and stops at the first match; 0 to ENTRIES entries
//   are scanned. The response becomes valid in the same cycle in which
//   req.ready returns.
//   One request is in the block at a time; a finished response waits in
//   the output register, and the next request may be accepted meanwhile.
//   If rsp.ready stays low, the following request completes its scan and
//   then holds until the output register frees.
//   Reset (rst, synchronous) empties the table at once: fill count and
//   head go to zero and RAM contents are simply ignored until written.
// ----------------------------------------------------------------------------
module fifo_evicting_key_value_table (
  input logic   clk,
  input logic   rst,
  kvt_req_if.sink   req,
  kvt_rsp_if.source rsp
);
  import kvt_pkg::*;

  kvt_state_t state, state_next;
  kvt_op_t    op_q;
  key_t       key_q;
  value_t     val_q;
  cnt_t       idx;
  cnt_t       fill;
  addr_t      head;
  addr_t      match_addr;
  logic       res_hit;
  value_t     res_rd;

  logic       rsp_valid;
  logic       rsp_hit;
  value_t     rsp_read_value;
  logic       rsp_evicted;

  addr_t      rd_addr;
  addr_t      wr_addr;
  key_t       key_rdata;
  logic [VAL_W-1:0] val_rdata;
  logic       key_we;
  logic       val_we;
  logic       accept;
  logic       key_match;
  logic       last_entry;
  logic       finish;
  logic       full;
  cnt_t       idx_inc;

  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign full      = (fill == cnt_t'(ENTRIES));
  assign idx_inc   = cnt_t'(idx + 1'b1);
  assign rd_addr   = wrap_addr(head, idx);
  assign key_match = (key_rdata == key_q);
  assign last_entry = (idx_inc == fill);

  // Writes happen only as a request finishes; the next read follows the return
  // to ST_IDLE and a new accept, so the read port never sees a stale entry.
  always_comb begin
    state_next = state;
    finish     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (fill == '0) ? ST_DONE : ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_CMP;
      end
      ST_CMP: begin
        if (key_match || last_entry) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_READ;
        end
      end
      ST_DONE: begin
        if (!rsp_valid || rsp.ready) begin
          finish     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    priority if (res_hit) begin
      wr_addr = match_addr;
    end else if (full) begin
      wr_addr = head;
    end else begin
      wr_addr = wrap_addr(head, fill);
    end
    val_we = finish && (op_q == OP_ADD);
    key_we = val_we && !res_hit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      head <= '0;
    end else if (key_we) begin
      if (full) begin
        head <= (head == addr_t'(ENTRIES - 1)) ? '0 : addr_t'(head + 1'b1);
      end else begin
        fill <= cnt_t'(fill + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q    <= req.op;
      key_q   <= req.key;
      val_q   <= req.entry_value;
      idx     <= '0;
      res_hit <= 1'b0;
      res_rd  <= '0;
    end else if (state == ST_CMP) begin
      if (key_match) begin
        res_hit    <= 1'b1;
        match_addr <= rd_addr;
        if (op_q == OP_ACCESS) begin
          res_rd <= value_t'(val_rdata);
        end
      end else begin
        idx <= idx_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (finish) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      rsp_hit        <= res_hit;
      rsp_read_value <= res_rd;
      rsp_evicted    <= (op_q == OP_ADD) && !res_hit && full;
    end
  end

  assign rsp.valid      = rsp_valid;
  assign rsp.hit        = rsp_hit;
  assign rsp.read_value = rsp_read_value;
  assign rsp.evicted    = rsp_evicted;

  kvt_ram #(
    .WIDTH (KEY_W),
    .DEPTH (ENTRIES)
  ) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (wr_addr),
    .wdata (key_q),
    .raddr (rd_addr),
    .rdata (key_rdata)
  );

  kvt_ram #(
    .WIDTH (VAL_W),
    .DEPTH (ENTRIES)
  ) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (wr_addr),
    .wdata (val_q),
    .raddr (rd_addr),
    .rdata (val_rdata)
  );

endmodule

// ===== design/kvt_checker.sv =====
// ----------------------------------------------------------------------------
// kvt_checker
// Port-level checks for the key/value table, bound to the top level.
// ----------------------------------------------------------------------------
`include "fifo_evicting_key_value_table_assert.svh"

module kvt_checker (
  input logic       clk,
  input logic       rst,
  kvt_req_if.sink   req,
  kvt_rsp_if.source rsp
);
  import kvt_pkg::*;

  // An eviction only follows an add of a key that was not stored.
  `KVT_ASSERT_SAME(a_evict_is_miss, rsp.valid && rsp.evicted, !rsp.hit,
                   "eviction reported together with a hit")

  // A nonzero read value can only come from a hit.
  `KVT_ASSERT_SAME(a_value_needs_hit, rsp.valid && (rsp.read_value != '0), rsp.hit,
                   "nonzero read value without a hit")

  // Requests are taken one at a time.
  `KVT_ASSERT_NEXT(a_one_in_flight, req.valid && req.ready, !req.ready,
                   "request accepted while another is in progress")

  // A stalled response word holds.
  `KVT_ASSERT_NEXT(a_rsp_hold, rsp.valid && !rsp.ready,
                   rsp.valid && $stable(rsp.hit) && $stable(rsp.read_value)
                   && $stable(rsp.evicted),
                   "stalled response word changed")

endmodule

bind fifo_evicting_key_value_table kvt_checker u_kvt_checker (.*);
